[src/ps2se_pkg.sv]
// ----------------------------------------------------------------------------
// ps2se_pkg
// Shared types and constants of the PS/2 to serial mouse encoder.
// ----------------------------------------------------------------------------
package ps2se_pkg;

   // Accumulator width and the depth of the packet queue.
   localparam int ACC_WIDTH_DEFAULT = 16;
   localparam int QUEUE_DEPTH       = 2;

   // Configuration port.
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 8;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPEED_STEP    = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPEED_MIN     = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPEED_MAX     = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPEED_DEFAULT = 3'd3;

   localparam logic [7:0] SPEED_STEP_RESET    = 8'd10;
   localparam logic [7:0] SPEED_MIN_RESET     = 8'd25;
   localparam logic [7:0] SPEED_MAX_RESET     = 8'd250;
   localparam logic [7:0] SPEED_DEFAULT_RESET = 8'd100;

   // Scaling by speed / 100. A product magnitude at or above SAT_PRODUCT
   // saturates the axis; below it the quotient comes from a reciprocal
   // multiply that is exact over that range.
   localparam int          MAG_WIDTH   = 15;
   localparam int          RECIP_WIDTH = 13;
   localparam int          RECIP_SHIFT = 19;
   localparam logic [12:0] RECIP_MULT  = 13'd5243;
   localparam int          SAT_PRODUCT = 25500;
   localparam logic [7:0]  MOTION_MAX  = 8'd255;
   localparam logic signed [7:0] WHEEL_MAX = 8'sd7;
   localparam logic signed [7:0] WHEEL_MIN = -8'sd7;

   // Serial byte codes.
   localparam logic [7:0] BYTE_SYNC   = 8'h40;
   localparam logic [7:0] BYTE_MIDDLE = 8'h20;
   localparam logic [7:0] BYTE_ZERO   = 8'h00;
   localparam logic [7:0] BYTE_ID_M   = 8'h4D;
   localparam logic [7:0] BYTE_ID_3   = 8'h33;
   localparam logic [7:0] LOW6_MASK   = 8'h3F;
   localparam logic [1:0] HIGH2_MASK  = 2'h3;

   // Input operation codes.
   localparam logic OP_REPORT = 1'b0;
   localparam logic OP_TICK   = 1'b1;

   // One tick's worth of output, handed from the front to the back.
   typedef struct packed {
      logic       pkt;
      logic       fourth;
      logic       mid_chg;
      logic       ident;
      logic [7:0] b0;
      logic [7:0] b1;
      logic [7:0] b2;
      logic [7:0] b3;
   } desc_type;

endpackage

[src/ps2se_if.sv]
// ----------------------------------------------------------------------------
// ps2se_if
// Request and response channel interfaces with valid/ready handshake.
// ----------------------------------------------------------------------------
interface ps2se_req_if;
   logic              valid;
   logic              ready;
   logic              op;
   logic              btn_left;
   logic              btn_right;
   logic              btn_middle;
   logic signed [8:0] move_x;
   logic signed [8:0] move_y;
   logic signed [3:0] move_wheel;
   logic              rts_level;

   modport source (output valid, op, btn_left, btn_right, btn_middle, move_x, move_y,
                   move_wheel, rts_level, input ready);
   modport sink (input valid, op, btn_left, btn_right, btn_middle, move_x, move_y,
                 move_wheel, rts_level, output ready);
endinterface

interface ps2se_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] serial_byte;
   logic       is_last;

   modport source (output valid, serial_byte, is_last, input ready);
   modport sink (input valid, serial_byte, is_last, output ready);
endinterface

[src/ps2se_queue.sv]
// ----------------------------------------------------------------------------
// ps2se_queue
// Small FIFO of packet descriptors between the front and the back.
// ----------------------------------------------------------------------------
module ps2se_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  ps2se_pkg::desc_type push_desc,
   output logic                full,
   output logic                head_valid,
   output ps2se_pkg::desc_type head_desc,
   input  logic                pop
);

   localparam int DEPTH = ps2se_pkg::QUEUE_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   ps2se_pkg::desc_type mem [DEPTH];

   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      ptr_next = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_desc  = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_desc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

[src/ps2se_front.sv]
// ----------------------------------------------------------------------------
// ps2se_front
// Accepts requests, accumulates reports and turns ticks into packet descriptors.
// ----------------------------------------------------------------------------
module ps2se_front #(
   parameter int ACC_WIDTH = ps2se_pkg::ACC_WIDTH_DEFAULT
) (
   input  logic                                      clock,
   input  logic                                      reset,
   ps2se_req_if.sink                                 req,
   input  logic                                      csr_we,
   input  logic [ps2se_pkg::CSR_INDEX_WIDTH-1:0]     csr_index,
   input  logic [ps2se_pkg::CSR_DATA_WIDTH-1:0]      csr_wdata,
   input  logic                                      q_full,
   output logic                                      push,
   output ps2se_pkg::desc_type                       push_desc
);

   localparam int W  = ACC_WIDTH;
   localparam int P  = ACC_WIDTH + 9;
   localparam int MW = ps2se_pkg::MAG_WIDTH;
   localparam int RW = ps2se_pkg::RECIP_WIDTH;
   localparam int QW = MW + RW;
   localparam int RS = ps2se_pkg::RECIP_SHIFT;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_MUL  = 2'd1;
   localparam logic [1:0] ST_ABS  = 2'd2;
   localparam logic [1:0] ST_FIN  = 2'd3;

   logic [1:0]          st_ff, st_in;
   logic signed [W-1:0] acc_ff [2];
   logic signed [W-1:0] acc_in [2];
   logic signed [7:0]   acc_w_ff, acc_w_in;
   logic [2:0]          held_ff, held_in;
   logic [2:0]          prev_btn_ff, prev_btn_in;
   logic signed [3:0]   prev_w_ff, prev_w_in;
   logic [7:0]          speed_ff, speed_in;
   logic                rts_seen_ff, rts_seen_in;
   logic                rts_lvl_ff;
   logic [7:0]          step_ff, min_ff, max_ff;

   // Scaling pipeline, lane 0 is x and lane 1 is y.
   logic signed [P-1:0] prod_ff [2];
   logic signed [P-1:0] prod_in [2];
   logic                neg_ff [2];
   logic                big_ff [2];
   logic [MW-1:0]       mag_ff [2];
   logic                neg_in [2];
   logic                big_in [2];
   logic [MW-1:0]       mag_in [2];

   logic                accept;
   logic                is_tick;
   logic signed [W:0]   sum [2];
   logic signed [8:0]   wsum;
   logic signed [7:0]   prev_w_sx;
   logic [8:0]          up_sum;
   logic signed [9:0]   dn_diff;
   logic [7:0]          speed_tick;
   logic [7:0]          cfg_speed;
   logic [7:0]          d_mag [2];
   logic [7:0]          d8 [2];
   logic                d_nz [2];
   logic [QW-1:0]       quot [2];
   logic [P-1:0]        pabs;
   logic signed [8:0]   spd_s;
   logic                w_nz;
   logic signed [7:0]   w_clamp;
   logic                event_any;
   logic                mb;
   logic                pm;
   logic                mid_chg;
   logic                rts_rise;

   assign req.ready = (st_ff == ST_IDLE) && !q_full;
   assign accept    = req.valid && req.ready;
   assign is_tick   = (req.op == ps2se_pkg::OP_TICK);

   // Configuration registers.
   always_comb begin
      cfg_speed = (csr_wdata < min_ff) ? min_ff : csr_wdata;
      cfg_speed = (cfg_speed > max_ff) ? max_ff : cfg_speed;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= ps2se_pkg::SPEED_STEP_RESET;
         min_ff  <= ps2se_pkg::SPEED_MIN_RESET;
         max_ff  <= ps2se_pkg::SPEED_MAX_RESET;
      end else if (csr_we) begin
         if (csr_index == ps2se_pkg::CSR_SPEED_STEP) begin
            step_ff <= csr_wdata;
         end
         if (csr_index == ps2se_pkg::CSR_SPEED_MIN) begin
            min_ff <= csr_wdata;
         end
         if (csr_index == ps2se_pkg::CSR_SPEED_MAX) begin
            max_ff <= csr_wdata;
         end
      end
   end

   // Speed step taken at the start of a tick.
   always_comb begin
      prev_w_sx  = 8'(prev_w_ff);
      up_sum     = {1'b0, speed_ff} + {1'b0, step_ff};
      dn_diff    = $signed({2'b00, speed_ff}) - $signed({2'b00, step_ff});
      speed_tick = speed_ff;
      if (acc_w_ff != prev_w_sx) begin
         if (acc_w_ff > 8'sd0) begin
            speed_tick = (up_sum > {1'b0, max_ff}) ? max_ff : up_sum[7:0];
         end else if (acc_w_ff < 8'sd0) begin
            speed_tick = (dn_diff < $signed({2'b00, min_ff})) ? min_ff : dn_diff[7:0];
         end
      end
   end

   // Multiply and magnitude stages.
   always_comb begin
      spd_s = $signed({1'b0, speed_ff});
      pabs  = '0;
      for (int i = 0; i < 2; i++) begin
         prod_in[i] = P'(acc_ff[i]) * P'(spd_s);
         neg_in[i]  = prod_ff[i][P-1];
         pabs       = neg_in[i] ? P'(-prod_ff[i]) : P'(prod_ff[i]);
         big_in[i]  = (pabs >= P'(ps2se_pkg::SAT_PRODUCT));
         mag_in[i]  = pabs[MW-1:0];
      end
   end

   // Final stage: quotient, clamp and packet bytes.
   always_comb begin
      for (int i = 0; i < 2; i++) begin
         quot[i]  = QW'(mag_ff[i]) * QW'(ps2se_pkg::RECIP_MULT);
         d_mag[i] = big_ff[i] ? ps2se_pkg::MOTION_MAX : quot[i][RS+7:RS];
         d_nz[i]  = big_ff[i] || (d_mag[i] != 8'd0);
         d8[i]    = neg_ff[i] ? 8'(-d_mag[i]) : d_mag[i];
      end
      w_nz     = (acc_w_ff != 8'sd0);
      w_clamp  = (acc_w_ff > ps2se_pkg::WHEEL_MAX) ? ps2se_pkg::WHEEL_MAX :
                 (acc_w_ff < ps2se_pkg::WHEEL_MIN) ? ps2se_pkg::WHEEL_MIN : acc_w_ff;
      event_any = d_nz[0] || d_nz[1] || w_nz || (held_ff != 3'd0) || (held_ff != prev_btn_ff);
      mb        = held_ff[2];
      pm        = prev_btn_ff[2];
      mid_chg   = (mb != pm);
      rts_rise  = rts_lvl_ff && !rts_seen_ff;

      push_desc.pkt     = event_any;
      push_desc.fourth  = event_any && (mb || pm);
      push_desc.mid_chg = mid_chg;
      push_desc.ident   = rts_rise;
      push_desc.b0      = ps2se_pkg::BYTE_SYNC | {2'b00, held_ff[0], held_ff[1],
                          d8[1][7:6] & ps2se_pkg::HIGH2_MASK,
                          d8[0][7:6] & ps2se_pkg::HIGH2_MASK};
      push_desc.b1      = d8[0] & ps2se_pkg::LOW6_MASK;
      push_desc.b2      = d8[1] & ps2se_pkg::LOW6_MASK;
      push_desc.b3      = mb ? ps2se_pkg::BYTE_MIDDLE : ps2se_pkg::BYTE_ZERO;
      push              = (st_ff == ST_FIN) && (event_any || mid_chg || rts_rise);
   end

   // Next state of the accumulators and tick bookkeeping.
   always_comb begin
      st_in       = st_ff;
      acc_in      = acc_ff;
      acc_w_in    = acc_w_ff;
      held_in     = held_ff;
      prev_btn_in = prev_btn_ff;
      prev_w_in   = prev_w_ff;
      speed_in    = speed_ff;
      rts_seen_in = rts_seen_ff;

      sum[0] = $signed({acc_ff[0][W-1], acc_ff[0]}) + (W+1)'(req.move_x);
      sum[1] = $signed({acc_ff[1][W-1], acc_ff[1]}) - (W+1)'(req.move_y);
      wsum   = $signed({acc_w_ff[7], acc_w_ff}) + 9'(req.move_wheel);

      unique case (st_ff)
         ST_IDLE: begin
            if (accept) begin
               if (is_tick) begin
                  speed_in = speed_tick;
                  st_in    = ST_MUL;
               end else begin
                  for (int i = 0; i < 2; i++) begin
                     if (sum[i][W] != sum[i][W-1]) begin
                        acc_in[i] = sum[i][W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
                     end else begin
                        acc_in[i] = sum[i][W-1:0];
                     end
                  end
                  if (wsum[8] != wsum[7]) begin
                     acc_w_in = wsum[8] ? -8'sd128 : 8'sd127;
                  end else begin
                     acc_w_in = wsum[7:0];
                  end
                  held_in = held_ff | {req.btn_middle, req.btn_right, req.btn_left};
               end
            end
         end
         ST_MUL: begin
            st_in = ST_ABS;
         end
         ST_ABS: begin
            st_in = ST_FIN;
         end
         ST_FIN: begin
            st_in = ST_IDLE;
            for (int i = 0; i < 2; i++) begin
               if (d_nz[i] || rts_rise) begin
                  acc_in[i] = '0;
               end
            end
            if (w_nz || rts_rise) begin
               acc_w_in = 8'sd0;
            end
            prev_btn_in = rts_rise ? 3'd0 : held_ff;
            prev_w_in   = w_clamp[3:0];
            held_in     = 3'd0;
            rts_seen_in = rts_lvl_ff;
         end
         default: begin
            st_in = ST_IDLE;
         end
      endcase

      // A write of the default speed reloads the current speed.
      if (csr_we && (csr_index == ps2se_pkg::CSR_SPEED_DEFAULT)) begin
         speed_in = cfg_speed;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff       <= ST_IDLE;
         acc_ff[0]   <= '0;
         acc_ff[1]   <= '0;
         acc_w_ff    <= '0;
         held_ff     <= '0;
         prev_btn_ff <= '0;
         prev_w_ff   <= '0;
         speed_ff    <= ps2se_pkg::SPEED_DEFAULT_RESET;
         rts_seen_ff <= 1'b0;
      end else begin
         st_ff       <= st_in;
         acc_ff      <= acc_in;
         acc_w_ff    <= acc_w_in;
         held_ff     <= held_in;
         prev_btn_ff <= prev_btn_in;
         prev_w_ff   <= prev_w_in;
         speed_ff    <= speed_in;
         rts_seen_ff <= rts_seen_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rts_lvl_ff <= req.rts_level;
      end
      if (st_ff == ST_MUL) begin
         prod_ff <= prod_in;
      end
      if (st_ff == ST_ABS) begin
         neg_ff <= neg_in;
         big_ff <= big_in;
         mag_ff <= mag_in;
      end
   end

endmodule

[src/ps2se_back.sv]
// ----------------------------------------------------------------------------
// ps2se_back
// Serialises queued packet descriptors into bytes on the response channel.
// ----------------------------------------------------------------------------
module ps2se_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   input  ps2se_pkg::desc_type q_head,
   output logic                q_pop,
   ps2se_rsp_if.source         rsp
);

   localparam int NPOS = 9;

   localparam logic [3:0] POS_B0    = 4'd0;
   localparam logic [3:0] POS_B1    = 4'd1;
   localparam logic [3:0] POS_B2    = 4'd2;
   localparam logic [3:0] POS_B3    = 4'd3;
   localparam logic [3:0] POS_MID0  = 4'd4;
   localparam logic [3:0] POS_MID1  = 4'd5;
   localparam logic [3:0] POS_MID2  = 4'd6;
   localparam logic [3:0] POS_ID_M  = 4'd7;
   localparam logic [3:0] POS_ID_3  = 4'd8;

   logic [NPOS-1:0] sent_ff, sent_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [7:0]      rsp_byte_ff;
   logic            rsp_last_ff;

   logic [NPOS-1:0] mask;
   logic [NPOS-1:0] remaining;
   logic [3:0]      cur_idx;
   logic            last;
   logic            load;
   logic [7:0]      cur_byte;

   always_comb begin
      mask = {q_head.ident, q_head.ident, q_head.mid_chg, q_head.mid_chg, q_head.mid_chg,
              q_head.fourth, q_head.pkt, q_head.pkt, q_head.pkt};
      remaining = mask & ~sent_ff;
      cur_idx   = POS_B0;
      for (int i = NPOS - 1; i >= 0; i--) begin
         if (remaining[i]) begin
            cur_idx = 4'(i);
         end
      end
      last = ((remaining & (remaining - NPOS'(1))) == '0);

      unique case (cur_idx)
         POS_B0:   cur_byte = q_head.b0;
         POS_B1:   cur_byte = q_head.b1;
         POS_B2:   cur_byte = q_head.b2;
         POS_B3:   cur_byte = q_head.b3;
         POS_MID0: cur_byte = ps2se_pkg::BYTE_SYNC;
         POS_MID1: cur_byte = ps2se_pkg::BYTE_ZERO;
         POS_MID2: cur_byte = ps2se_pkg::BYTE_ZERO;
         POS_ID_M: cur_byte = ps2se_pkg::BYTE_ID_M;
         POS_ID_3: cur_byte = ps2se_pkg::BYTE_ID_3;
         default:  cur_byte = ps2se_pkg::BYTE_ZERO;
      endcase

      // The output register is refilled from the queue head whenever it is empty or being taken.
      load  = q_valid && (!rsp_valid_ff || rsp.ready);
      q_pop = load && last;

      sent_in = sent_ff;
      if (load) begin
         sent_in = last ? '0 : (sent_ff | (NPOS'(1) << cur_idx));
      end

      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sent_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sent_ff      <= sent_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_byte_ff <= cur_byte;
         rsp_last_ff <= last;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.serial_byte = rsp_byte_ff;
   assign rsp.is_last     = rsp_last_ff;

endmodule

[src/ps2_to_serial_mouse_encoder_core.sv]
// ----------------------------------------------------------------------------
// ps2_to_serial_mouse_encoder_core
// A report request is accepted while the front is idle and the queue is not
// full; a tick occupies the front through speed step, multiply, magnitude,
// and quotient and packet build. Its first byte goes through the queue, then
// one byte per cycle from the output register while the sink is ready.
// Synchronous active-high reset clears the control state and loads register defaults.
// ----------------------------------------------------------------------------
module ps2_to_serial_mouse_encoder_core #(
   parameter int ACC_WIDTH = ps2se_pkg::ACC_WIDTH_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   ps2se_req_if.sink                             req_if,
   ps2se_rsp_if.source                           rsp_if,
   input  logic                                  csr_we,
   input  logic [ps2se_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [ps2se_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);

   logic                push;
   ps2se_pkg::desc_type push_desc;
   logic                q_full;
   logic                q_valid;
   ps2se_pkg::desc_type q_head;
   logic                q_pop;

   ps2se_front #(
      .ACC_WIDTH (ACC_WIDTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .q_full    (q_full),
      .push      (push),
      .push_desc (push_desc)
   );

   ps2se_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_desc  (push_desc),
      .full       (q_full),
      .head_valid (q_valid),
      .head_desc  (q_head),
      .pop        (q_pop)
   );

   ps2se_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_head  (q_head),
      .q_pop   (q_pop),
      .rsp     (rsp_if)
   );

endmodule
